[sv/lcdx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_pkg
// Shared types, codes and the power-up table for the character LCD sequencer.
// ----------------------------------------------------------------------------
package lcdx_pkg;

  // Request codes
  typedef enum logic [2:0] {
    CMD_INIT          = 3'd0,
    CMD_PRINT         = 3'd1,
    CMD_ERASE         = 3'd2,
    CMD_CURSOR        = 3'd3,
    CMD_DISPLAY_ON    = 3'd4,
    CMD_DISPLAY_OFF   = 3'd5,
    CMD_BACKLIGHT_ON  = 3'd6,
    CMD_BACKLIGHT_OFF = 3'd7
  } cmd_t;

  // Pause codes carried with each expander byte
  typedef enum logic [2:0] {
    PAUSE_NONE    = 3'd0,
    PAUSE_100US   = 3'd1,
    PAUSE_4MS     = 3'd2,
    PAUSE_CLEAR   = 3'd3,
    PAUSE_POWERUP = 3'd4
  } pause_t;

  // Configuration register indexes
  localparam logic [2:0] REG_COLUMNS       = 3'd0;
  localparam logic [2:0] REG_ROWS          = 3'd1;
  localparam logic [2:0] REG_LINK_READY    = 3'd2;
  localparam logic [2:0] REG_RS_PIN        = 3'd3;
  localparam logic [2:0] REG_ENABLE_PIN    = 3'd4;
  localparam logic [2:0] REG_BACKLIGHT_PIN = 3'd5;
  localparam logic [2:0] REG_DATA_PIN_MAP  = 3'd6;

  // Display command bytes
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_CTRL_OFF  = 8'h08;
  localparam logic [7:0] LCD_CTRL_ON   = 8'h0C;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

  // Step counter: a normal request is 4 beats, power-up is 33
  localparam logic [5:0] STEP_NORMAL_LAST = 6'd3;
  localparam logic [5:0] STEP_INIT_LAST   = 6'd32;
  // Nibbles of the power-up sequence from this one on go out with backlight lit
  localparam logic [3:0] INIT_BL_FIRST    = 4'd12;

  typedef struct packed {
    logic [5:0]  columns;
    logic [1:0]  rows;
    logic        link_ready;
    logic [2:0]  rs_pin;
    logic [2:0]  enable_pin;
    logic [2:0]  backlight_pin;
    logic [11:0] data_pin_map;
  } cfg_t;

  // One classified request waiting for the back end
  typedef struct packed {
    logic       is_init;
    logic [7:0] value;
    logic       is_data;
    logic       backlight;
    pause_t     pause;
  } q_entry_t;

  // Nibbles sent after the initial port byte of the power-up sequence
  function automatic logic [3:0] init_nibble(input logic [3:0] j);
    logic [3:0] n;
    case (j)
      4'd0:    n = 4'h3;
      4'd1:    n = 4'h3;
      4'd2:    n = 4'h3;
      4'd3:    n = 4'h2;
      4'd4:    n = 4'h2;
      4'd5:    n = 4'h8;
      4'd6:    n = 4'h0;
      4'd7:    n = 4'h8;
      4'd8:    n = 4'h0;
      4'd9:    n = 4'h1;
      4'd10:   n = 4'h0;
      4'd11:   n = 4'h6;
      4'd12:   n = 4'h0;
      4'd13:   n = 4'h8;
      4'd14:   n = 4'h0;
      4'd15:   n = 4'hC;
      default: n = 4'h0;
    endcase
    return n;
  endfunction

  // Pause after the strobe-low byte of each power-up nibble
  function automatic pause_t init_pause(input logic [3:0] j);
    pause_t p;
    case (j)
      4'd0:    p = PAUSE_4MS;
      4'd1:    p = PAUSE_100US;
      4'd2:    p = PAUSE_100US;
      4'd9:    p = PAUSE_CLEAR;
      default: p = PAUSE_NONE;
    endcase
    return p;
  endfunction

endpackage

[sv/lcdx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_front
// Accepts requests, tracks display and backlight state, and turns each
// request taken with the link ready into one queue entry for the byte sequencer.
// ----------------------------------------------------------------------------
module lcdx_front
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [2:0] cmd,
  input  logic [7:0] char_code,
  input  logic [7:0] col,
  input  logic [7:0] row,
  output logic       push,
  output q_entry_t   entry
);

  logic       display_enabled_r, display_enabled_nxt;
  logic       backlight_lit_r, backlight_lit_nxt;
  logic       disp_upd, bl_upd;
  logic [5:0] width, col_c;
  logic [1:0] height, row_c;
  logic [7:0] cursor_addr;

  // State after the display and backlight requests
  always_comb begin
    disp_upd = display_enabled_r;
    bl_upd   = backlight_lit_r;
    case (cmd_t'(cmd))
      CMD_DISPLAY_ON:    disp_upd = 1'b1;
      CMD_DISPLAY_OFF:   disp_upd = 1'b0;
      CMD_BACKLIGHT_ON:  bl_upd   = 1'b1;
      CMD_BACKLIGHT_OFF: bl_upd   = 1'b0;
      default: ;
    endcase
    display_enabled_nxt = display_enabled_r;
    backlight_lit_nxt   = backlight_lit_r;
    if (accept) begin
      display_enabled_nxt = disp_upd;
      backlight_lit_nxt   = bl_upd;
      // a completed power-up leaves display and backlight on
      if (cfg.link_ready && cmd_t'(cmd) == CMD_INIT) begin
        display_enabled_nxt = 1'b1;
        backlight_lit_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enabled_r <= 1'b0;
      backlight_lit_r   <= 1'b0;
    end else begin
      display_enabled_r <= display_enabled_nxt;
      backlight_lit_r   <= backlight_lit_nxt;
    end
  end

  // Cursor clamp; zero columns or rows count as one
  always_comb begin
    width  = (cfg.columns == 6'd0) ? 6'd1 : cfg.columns;
    height = (cfg.rows == 2'd0) ? 2'd1 : cfg.rows;
    col_c  = (col >= {2'b00, width}) ? width - 6'd1 : col[5:0];
    row_c  = (row >= {6'b0, height}) ? height - 2'd1 : row[1:0];
    cursor_addr = LCD_SET_DDRAM | ({2'b00, col_c} + {row_c, 6'b0});
  end

  // Classification into a queue entry
  always_comb begin
    entry.is_init   = 1'b0;
    entry.value     = disp_upd ? LCD_CTRL_ON : LCD_CTRL_OFF;
    entry.is_data   = 1'b0;
    entry.backlight = bl_upd;
    entry.pause     = PAUSE_NONE;
    case (cmd_t'(cmd))
      CMD_INIT:   entry.is_init = 1'b1;
      CMD_PRINT: begin
        entry.value   = char_code;
        entry.is_data = 1'b1;
      end
      CMD_ERASE: begin
        entry.value = LCD_CLEAR;
        entry.pause = PAUSE_CLEAR;
      end
      CMD_CURSOR: entry.value = cursor_addr;
      default: ;
    endcase
  end

  // with the link down the request only updates state
  assign push = accept && cfg.link_ready;

endmodule

[sv/lcdx_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_fifo
// Short request queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module lcdx_fifo
  import lcdx_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  q_entry_t      mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("lcdx_fifo: push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> !pop)
    else $error("lcdx_fifo: pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("lcdx_fifo: fill count out of range");

endmodule

[sv/lcdx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdx_back
// Byte sequencer: walks each queued request through its expander bytes,
// one beat per cycle into the output register, unless the sink stalls.
// ----------------------------------------------------------------------------
module lcdx_back
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_pause,
  output logic       out_last
);

  logic [5:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  pause_t     out_pause_r, out_pause_nxt;
  logic       out_last_r, out_last_nxt;

  logic       advance, fire, last;
  logic [4:0] k;
  logic [3:0] nib_idx, nib;
  logic       phase, is_raw, bl, rs;
  pause_t     pause;
  logic [7:0] pins, en_mask;

  assign advance = !out_valid_r || out_ready;
  assign fire    = q_valid && advance;
  assign k       = step_r[4:0] - 5'd1;
  assign nib_idx = k[4:1];

  // Which nibble, phase and flags this step sends
  always_comb begin
    if (q_head.is_init) begin
      is_raw = (step_r == 6'd0);
      phase  = k[0];
      nib    = init_nibble(nib_idx);
      rs     = 1'b0;
      bl     = (nib_idx >= INIT_BL_FIRST);
      if (is_raw)     pause = PAUSE_POWERUP;
      else if (phase) pause = init_pause(nib_idx);
      else            pause = PAUSE_NONE;
      last   = (step_r == STEP_INIT_LAST);
    end else begin
      is_raw = 1'b0;
      phase  = step_r[0];
      nib    = step_r[1] ? q_head.value[3:0] : q_head.value[7:4];
      rs     = q_head.is_data;
      bl     = q_head.backlight;
      last   = (step_r == STEP_NORMAL_LAST);
      pause  = last ? q_head.pause : PAUSE_NONE;
    end
  end

  // Map the nibble and control bits onto the expander pins
  always_comb begin
    pins = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (nib[i]) pins = pins | (8'h01 << cfg.data_pin_map[3*i +: 3]);
    end
    if (rs) pins = pins | (8'h01 << cfg.rs_pin);
    if (bl) pins = pins | (8'h01 << cfg.backlight_pin);
    en_mask = 8'h01 << cfg.enable_pin;
  end

  // Step counter and output register
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pause_nxt = out_pause_r;
    out_last_nxt  = out_last_r;
    if (advance) out_valid_nxt = q_valid;
    if (fire) begin
      step_nxt      = last ? 6'd0 : step_r + 6'd1;
      out_pause_nxt = pause;
      out_last_nxt  = last;
      if (is_raw)     out_byte_nxt = 8'h00;
      else if (phase) out_byte_nxt = pins & ~en_mask;
      else            out_byte_nxt = pins | en_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_pause_r <= out_pause_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign q_pop     = fire && last;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_pause = out_pause_r;
  assign out_last  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) step_r <= STEP_INIT_LAST)
    else $error("lcdx_back: step counter overran");
  assert property (@(posedge clk) disable iff (!rst_n) (step_r != 6'd0) |-> q_valid)
    else $error("lcdx_back: request left the queue mid-sequence");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (q_valid && !q_head.is_init) |-> (step_r <= STEP_NORMAL_LAST))
    else $error("lcdx_back: normal request beyond four beats");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_last_r)
    else $error("lcdx_back: request retired without a last beat");

endmodule

[sv/char_lcd_expander_sequencer.sv]
`timescale 1ns / 1ps
// A request is registered in the queue, then its beats in the sequencer output register.
// One output beat per cycle while a request is queued and the sink is ready; the byte
//   sequencer walks its steps, and the queue lets new requests in while it has room.
// A request seen with the link down is accepted and yields no beat.
// Reset (rst_n low, synchronous): queue and sequencer empty, display and
//   backlight off, registers at their defaults.
// ----------------------------------------------------------------------------
// char_lcd_expander_sequencer
// Converts character LCD requests into 4-bit-mode expander port bytes.
// ----------------------------------------------------------------------------
module char_lcd_expander_sequencer
  import lcdx_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  // requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[2:0], char_code[10:3], col[18:11], row[26:19]
  // expander bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // expander_byte[7:0], pause_after[10:8]
  output logic        out_tlast
);

  cfg_t       cfg_r, cfg_nxt;
  logic       accept, push, full, pop, head_valid;
  q_entry_t   entry, head;
  logic [7:0] exp_byte;
  logic [2:0] pause_after;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_COLUMNS:       cfg_nxt.columns       = cfg_wdata[5:0];
        REG_ROWS:          cfg_nxt.rows          = cfg_wdata[1:0];
        REG_LINK_READY:    cfg_nxt.link_ready    = cfg_wdata[0];
        REG_RS_PIN:        cfg_nxt.rs_pin        = cfg_wdata[2:0];
        REG_ENABLE_PIN:    cfg_nxt.enable_pin    = cfg_wdata[2:0];
        REG_BACKLIGHT_PIN: cfg_nxt.backlight_pin = cfg_wdata[2:0];
        REG_DATA_PIN_MAP:  cfg_nxt.data_pin_map  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns       <= 6'd16;
      cfg_r.rows          <= 2'd2;
      cfg_r.link_ready    <= 1'b1;
      cfg_r.rs_pin        <= 3'd0;
      cfg_r.enable_pin    <= 3'd2;
      cfg_r.backlight_pin <= 3'd3;
      cfg_r.data_pin_map  <= 12'd4012;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  lcdx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .cmd       (in_tdata[2:0]),
    .char_code (in_tdata[10:3]),
    .col       (in_tdata[18:11]),
    .row       (in_tdata[26:19]),
    .push      (push),
    .entry     (entry)
  );

  lcdx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lcdx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (head_valid),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (exp_byte),
    .out_pause (pause_after),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, pause_after, exp_byte};

endmodule

[test/lcd_beat_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_beat_checker
// Watches the request, expander-byte and register-write channels of the LCD
// sequencer. It keeps its own copy of the registers and of the display and
// backlight state, expands every accepted request into the expander bytes it
// must produce, and compares each output beat field by field against them.
// ----------------------------------------------------------------------------
module lcd_beat_checker
  import lcdx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd[2:0], char_code[10:3], col[18:11], row[26:19]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // expander_byte[7:0], pause_after[10:8]
  input  logic        out_tlast,
  output int          mismatches,
  output int          pending
);

  // Display commands used only by the power-up sequence
  localparam logic [7:0] LCD_FUNC_4BIT_2LINE = 8'h28;
  localparam logic [7:0] LCD_ENTRY_INC       = 8'h06;
  localparam logic [3:0] WAKE_NIBBLE         = 4'h3;
  localparam logic [3:0] MODE4_NIBBLE        = 4'h2;
  localparam logic [7:0] PORT_IDLE           = 8'h00;

  typedef struct packed {
    logic [7:0] port;
    pause_t     pause;
    logic       tail;
  } port_beat_t;

  port_beat_t port_beats_q[$];
  cfg_t       regs;
  logic       disp_on;
  logic       bl_lit;

  initial mismatches = 0;
  initial pending = 0;

  task automatic push_beat(input logic [7:0] b, input pause_t p);
    port_beat_t e;
    e.port  = b;
    e.pause = p;
    e.tail  = 1'b0;
    port_beats_q.push_back(e);
  endtask

  // One nibble: strobe high, then strobe low carrying the pause
  task automatic push_nibble(input logic [3:0] v, input logic is_data, input pause_t p);
    logic [7:0] pins;
    logic [7:0] strobe_hi;
    logic [7:0] strobe_lo;
    pins = '0;
    for (int i = 0; i < 4; i++)
      if (v[i]) pins[regs.data_pin_map[3*i +: 3]] = 1'b1;
    if (is_data) pins[regs.rs_pin] = 1'b1;
    if (bl_lit) pins[regs.backlight_pin] = 1'b1;
    strobe_hi = pins;
    strobe_hi[regs.enable_pin] = 1'b1;
    strobe_lo = pins;
    strobe_lo[regs.enable_pin] = 1'b0;
    push_beat(strobe_hi, PAUSE_NONE);
    push_beat(strobe_lo, p);
  endtask

  task automatic push_octet(input logic [7:0] v, input logic is_data, input pause_t p);
    push_nibble(v[7:4], is_data, PAUSE_NONE);
    push_nibble(v[3:0], is_data, p);
  endtask

  function automatic logic [7:0] ctrl_cmd();
    return disp_on ? LCD_CTRL_ON : LCD_CTRL_OFF;
  endfunction

  // Expand one request into its expander bytes
  task automatic predict_request(input logic [31:0] req);
    cmd_t       c;
    logic [7:0] ch;
    logic [7:0] x;
    logic [7:0] y;
    logic [5:0] w;
    logic [1:0] h;
    logic [7:0] addr;
    port_beat_t e;
    c  = cmd_t'(req[2:0]);
    ch = req[10:3];
    x  = req[18:11];
    y  = req[26:19];

    // state moves even with the link down
    case (c)
      CMD_DISPLAY_OFF:   disp_on = 1'b0;
      CMD_DISPLAY_ON:    disp_on = 1'b1;
      CMD_BACKLIGHT_ON:  bl_lit = 1'b1;
      CMD_BACKLIGHT_OFF: bl_lit = 1'b0;
      default: ;
    endcase
    if (!regs.link_ready) return;

    case (c)
      CMD_INIT: begin
        bl_lit = 1'b0;
        push_beat(PORT_IDLE, PAUSE_POWERUP);
        push_nibble(WAKE_NIBBLE, 1'b0, PAUSE_4MS);
        push_nibble(WAKE_NIBBLE, 1'b0, PAUSE_100US);
        push_nibble(WAKE_NIBBLE, 1'b0, PAUSE_100US);
        push_nibble(MODE4_NIBBLE, 1'b0, PAUSE_NONE);
        push_octet(LCD_FUNC_4BIT_2LINE, 1'b0, PAUSE_NONE);
        disp_on = 1'b0;
        push_octet(ctrl_cmd(), 1'b0, PAUSE_NONE);
        push_octet(LCD_CLEAR, 1'b0, PAUSE_CLEAR);
        push_octet(LCD_ENTRY_INC, 1'b0, PAUSE_NONE);
        bl_lit = 1'b1;
        push_octet(ctrl_cmd(), 1'b0, PAUSE_NONE);
        disp_on = 1'b1;
        push_octet(ctrl_cmd(), 1'b0, PAUSE_NONE);
      end
      CMD_PRINT: push_octet(ch, 1'b1, PAUSE_NONE);
      CMD_ERASE: push_octet(LCD_CLEAR, 1'b0, PAUSE_CLEAR);
      CMD_CURSOR: begin
        // zero width or height acts as one
        w = (regs.columns == 6'd0) ? 6'd1 : regs.columns;
        h = (regs.rows == 2'd0) ? 2'd1 : regs.rows;
        if (x >= {2'b00, w}) x = {2'b00, w - 6'd1};
        if (y >= {6'd0, h}) y = {6'd0, h - 2'd1};
        addr = x + (y << 6);
        push_octet(LCD_SET_DDRAM | addr, 1'b0, PAUSE_NONE);
      end
      default: push_octet(ctrl_cmd(), 1'b0, PAUSE_NONE);
    endcase

    // mark the closing byte of the request
    e = port_beats_q.pop_back();
    e.tail = 1'b1;
    port_beats_q.push_back(e);
  endtask

  task automatic check_beat();
    port_beat_t e;
    if (port_beats_q.size() == 0) begin
      $error("unexpected beat: expander_byte %02h", out_tdata[7:0]);
      mismatches++;
      return;
    end
    e = port_beats_q.pop_front();
    if (out_tdata[7:0] !== e.port) begin
      $error("expander_byte: expected %02h, got %02h", e.port, out_tdata[7:0]);
      mismatches++;
    end
    if (out_tdata[10:8] !== e.pause) begin
      $error("pause_after: expected %0d, got %0d", e.pause, out_tdata[10:8]);
      mismatches++;
    end
    if (out_tlast !== e.tail) begin
      $error("last: expected %0b, got %0b", e.tail, out_tlast);
      mismatches++;
    end
  endtask

  // Sample all channels at the edge where beats are taken
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.columns       = 6'd16;
      regs.rows          = 2'd2;
      regs.link_ready    = 1'b1;
      regs.rs_pin        = 3'd0;
      regs.enable_pin    = 3'd2;
      regs.backlight_pin = 3'd3;
      regs.data_pin_map  = 12'd4012;
      disp_on = 1'b0;
      bl_lit  = 1'b0;
      port_beats_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_COLUMNS:       regs.columns       = cfg_wdata[5:0];
          REG_ROWS:          regs.rows          = cfg_wdata[1:0];
          REG_LINK_READY:    regs.link_ready    = cfg_wdata[0];
          REG_RS_PIN:        regs.rs_pin        = cfg_wdata[2:0];
          REG_ENABLE_PIN:    regs.enable_pin    = cfg_wdata[2:0];
          REG_BACKLIGHT_PIN: regs.backlight_pin = cfg_wdata[2:0];
          REG_DATA_PIN_MAP:  regs.data_pin_map  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_request(in_tdata);
      if (out_tvalid && out_tready) check_beat();
    end
    pending = port_beats_q.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the LCD sequencer with directed and random requests across several
// register settings, with bursty request traffic and a stalling byte sink.
// The checker beside the block predicts and compares; this module reports.
// ----------------------------------------------------------------------------
module tb_top
  import lcdx_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_SLACK  = 12;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_TRICKLE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_COLUMNS;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // cmd[2:0], char_code[10:3], col[18:11], row[26:19]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // expander_byte[7:0], pause_after[10:8]
  logic        out_tlast;

  int          mismatches;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          rx_window = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  logic [1:0]  rx_phase = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  char_lcd_expander_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lcd_beat_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Byte sink: stall pattern switches between modes over random windows
  always @(posedge clk) begin
    if (rx_window == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      rx_window <= $urandom_range(20, 120);
    end else begin
      rx_window <= rx_window - 1;
    end
    rx_phase <= rx_phase + 2'd1;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_EVERY4: out_tready <= (rx_phase == 2'd0);
      default:   out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [31:0] pack_req(cmd_t c, logic [7:0] ch, logic [7:0] col,
                                           logic [7:0] row);
    return {5'd0, row, col, ch, c};
  endfunction

  // Mostly small cursor coordinates so clamping goes both ways
  function automatic logic [31:0] random_req(int init_odds);
    cmd_t       c;
    logic [7:0] col;
    logic [7:0] row;
    if ($urandom_range(0, init_odds) == 0) c = CMD_INIT;
    else c = cmd_t'($urandom_range(1, 7));
    col = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 63)) : 8'($urandom);
    row = ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return pack_req(c, 8'($urandom), col, row);
  endfunction

  // Holds a beat until it is taken; tvalid stays up for the next one
  task automatic send_req(input logic [31:0] req);
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [11:0] cols, input logic [11:0] rows,
                             input logic [11:0] link, input logic [11:0] rs,
                             input logic [11:0] en, input logic [11:0] bl,
                             input logic [11:0] pin_map);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_LINK_READY, link);
    write_reg(REG_RS_PIN, rs);
    write_reg(REG_ENABLE_PIN, en);
    write_reg(REG_BACKLIGHT_PIN, bl);
    write_reg(REG_DATA_PIN_MAP, pin_map);
    cfg_we <= 1'b0;
  endtask

  // Wait for every predicted byte, then let link-down requests clear out
  task automatic drain();
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Random requests in bursts with random gaps, some bursts back to back
  task automatic run_requests(input int count, input int init_odds);
    int gap;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      send_req(random_req(init_odds));
      burst_left--;
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults, printing before and after power-up, clamping, state
    send_req(pack_req(CMD_PRINT, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_PRINT, 8'hFF, 8'hFF, 8'hFF));
    send_req(pack_req(CMD_INIT, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_PRINT, 8'hA5, 8'h00, 8'h00));
    send_req(pack_req(CMD_PRINT, 8'h5A, 8'h00, 8'h00));
    send_req(pack_req(CMD_ERASE, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'hFF, 8'hFF));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'd15, 8'd1));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'd16, 8'd2));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'd7, 8'd0));
    send_req(pack_req(CMD_DISPLAY_OFF, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_DISPLAY_ON, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_BACKLIGHT_OFF, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_PRINT, 8'h3C, 8'h00, 8'h00));
    send_req(pack_req(CMD_BACKLIGHT_ON, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_DISPLAY_ON, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_INIT, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_CURSOR, 8'h00, 8'h80, 8'h01));
    send_req(pack_req(CMD_BACKLIGHT_OFF, 8'h00, 8'h00, 8'h00));
    send_req(pack_req(CMD_INIT, 8'h00, 8'h00, 8'h00));
    in_tvalid <= 1'b0;
    drain();

    // Forty columns, one row, every pin on bit 7
    load_config(12'd40, 12'd1, 12'd1, 12'd7, 12'd7, 12'd7, 12'hFFF);
    run_requests(18, 8);
    drain();

    // Narrowest display, every pin on bit 0
    load_config(12'd1, 12'd2, 12'd1, 12'd0, 12'd0, 12'd0, 12'h000);
    run_requests(18, 8);
    drain();

    // Zero width and height act as one
    load_config(12'd0, 12'd0, 12'd1, 12'd1, 12'd5, 12'd6, 12'($urandom_range(0, 4095)));
    run_requests(18, 8);
    drain();

    // Link down: state still moves, nothing comes out
    load_config(12'd16, 12'd2, 12'd0, 12'd0, 12'd2, 12'd3, 12'd4012);
    send_req(pack_req(CMD_INIT, 8'h00, 8'h00, 8'h00));
    run_requests(15, 4);
    drain();

    // Register maxima, random pins
    load_config(12'd63, 12'd3, 12'd1, 12'($urandom_range(0, 7)), 12'($urandom_range(0, 7)),
                12'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
    run_requests(14, 8);
    drain();

    // Typical random setting
    load_config(12'($urandom_range(1, 40)), 12'($urandom_range(1, 2)), 12'd1,
                12'($urandom_range(0, 7)), 12'($urandom_range(0, 7)),
                12'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)));
    run_requests(15, 8);
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/lcdx_pkg.sv
sv/lcdx_front.sv
sv/lcdx_fifo.sv
sv/lcdx_back.sv
sv/char_lcd_expander_sequencer.sv
test/lcd_beat_checker.sv
test/tb_top.sv
